[rtl/core/tilt_pkg.sv]
// ----------------------------------------------------------------------------
// tilt_pkg
// Shared constants, types and the arctangent table for the tilt angle core.
// ----------------------------------------------------------------------------
package tilt_pkg;

  localparam int CORDIC_STEPS = 24;   // number of CORDIC cells, 16..32
  localparam int FRAC_BITS    = 24;   // fractional bits of the degree scale
  localparam int SAMPLE_W     = 13;   // accelerometer sample width
  localparam int ANGLE_W      = 9;    // output angle width
  localparam int XY_W         = 40;   // CORDIC x/y datapath width
  localparam int Z_W          = 34;   // CORDIC angle accumulator width
  localparam int TABLE_IDX_W  = 5;    // arctangent table has 32 entries
  localparam int WHOLE_W      = 7;    // integer degrees of theta, 0..91

  localparam logic [Z_W-1:0] FRAC_MASK = (Z_W'(1) << FRAC_BITS) - Z_W'(1);
  localparam logic [Z_W-1:0] DEG90_Q   = Z_W'(90) << FRAC_BITS;
  localparam logic [Z_W-1:0] DEG90_Q1  = (Z_W'(90) << FRAC_BITS) + Z_W'(1);
  localparam logic [Z_W-1:0] DEG45_Q1  = (Z_W'(45) << FRAC_BITS) + Z_W'(1);

  localparam logic [ANGLE_W-1:0] ANG_HALF = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] ANG_FULL = ANGLE_W'(360);

  // how theta is obtained for one sample
  typedef enum logic [1:0] {
    KIND_FLAT   = 2'd0,   // y is zero: theta is 0
    KIND_VERT   = 2'd1,   // x is zero: theta is 90 plus one lsb
    KIND_DIAG   = 2'd2,   // |x| == |y|: theta is 45 plus one lsb
    KIND_CORDIC = 2'd3    // general case
  } tilt_kind_t;

  typedef struct packed {
    logic       x_neg;
    logic       x_zero;
    logic       y_neg;
    logic       y_zero;
    tilt_kind_t kind;
  } tilt_meta_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    tilt_meta_t             meta;
  } tilt_cell_t;

  // atan(2^-i) in degrees (pi = 3.14159265), scaled by 2^24, rounded
  function automatic logic [Z_W-1:0] atan_q24(input logic [TABLE_IDX_W-1:0] idx);
    logic [Z_W-1:0] val;
    case (idx)
      5'd0:    val = Z_W'(754974721);
      5'd1:    val = Z_W'(445687602);
      5'd2:    val = Z_W'(235489089);
      5'd3:    val = Z_W'(119537938);
      5'd4:    val = Z_W'(60000934);
      5'd5:    val = Z_W'(30029717);
      5'd6:    val = Z_W'(15018523);
      5'd7:    val = Z_W'(7509720);
      5'd8:    val = Z_W'(3754917);
      5'd9:    val = Z_W'(1877466);
      5'd10:   val = Z_W'(938734);
      5'd11:   val = Z_W'(469367);
      5'd12:   val = Z_W'(234684);
      5'd13:   val = Z_W'(117342);
      5'd14:   val = Z_W'(58671);
      5'd15:   val = Z_W'(29335);
      5'd16:   val = Z_W'(14668);
      5'd17:   val = Z_W'(7334);
      5'd18:   val = Z_W'(3667);
      5'd19:   val = Z_W'(1833);
      5'd20:   val = Z_W'(917);
      5'd21:   val = Z_W'(458);
      5'd22:   val = Z_W'(229);
      5'd23:   val = Z_W'(115);
      5'd24:   val = Z_W'(57);
      5'd25:   val = Z_W'(29);
      5'd26:   val = Z_W'(14);
      5'd27:   val = Z_W'(7);
      5'd28:   val = Z_W'(4);
      5'd29:   val = Z_W'(2);
      5'd30:   val = Z_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

[rtl/core/tilt_if.sv]
// ----------------------------------------------------------------------------
// tilt_in_if / tilt_out_if
// Valid/ready channels for the x,y sample pair and the resulting angle.
// ----------------------------------------------------------------------------
interface tilt_in_if import tilt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] accel_x;
  logic signed [SAMPLE_W-1:0] accel_y;

  modport source (output valid, output accel_x, output accel_y, input ready);
  modport sink   (input valid, input accel_x, input accel_y, output ready);
endinterface

interface tilt_out_if import tilt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle_deg;

  modport source (output valid, output angle_deg, input ready);
  modport sink   (input valid, input angle_deg, output ready);
endinterface

[rtl/core/tilt_prep.sv]
// ----------------------------------------------------------------------------
// tilt_prep
// Input stage: magnitudes, sign flags and special-case class of a sample.
// ----------------------------------------------------------------------------
module tilt_prep import tilt_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic signed [SAMPLE_W-1:0] up_x,
  input  logic signed [SAMPLE_W-1:0] up_y,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output tilt_cell_t                 dn_data
);

  logic          valid_r;
  tilt_cell_t    data_r;
  tilt_cell_t    data_nxt;
  logic [SAMPLE_W-1:0] ax;
  logic [SAMPLE_W-1:0] ay;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    // magnitude of -4096 is 4096, still fits 13 unsigned bits
    ax = up_x[SAMPLE_W-1] ? (~SAMPLE_W'(up_x) + SAMPLE_W'(1)) : SAMPLE_W'(up_x);
    ay = up_y[SAMPLE_W-1] ? (~SAMPLE_W'(up_y) + SAMPLE_W'(1)) : SAMPLE_W'(up_y);
    data_nxt.x           = $signed(XY_W'(ax) << FRAC_BITS);
    data_nxt.y           = $signed(XY_W'(ay) << FRAC_BITS);
    data_nxt.z           = '0;
    data_nxt.meta.x_neg  = up_x[SAMPLE_W-1];
    data_nxt.meta.x_zero = (ax == '0);
    data_nxt.meta.y_neg  = up_y[SAMPLE_W-1];
    data_nxt.meta.y_zero = (ay == '0);
    if (ay == '0) begin
      data_nxt.meta.kind = KIND_FLAT;
    end else if (ax == '0) begin
      data_nxt.meta.kind = KIND_VERT;
    end else if (ax == ay) begin
      data_nxt.meta.kind = KIND_DIAG;
    end else begin
      data_nxt.meta.kind = KIND_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[rtl/core/tilt_cell.sv]
// ----------------------------------------------------------------------------
// tilt_cell
// One vectoring CORDIC micro-rotation with its own register and handshake.
// ----------------------------------------------------------------------------
module tilt_cell import tilt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [TABLE_IDX_W-1:0] stage_idx,   // tied to the cell position
  input  logic                   up_valid,
  output logic                   up_ready,
  input  tilt_cell_t             up_data,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output tilt_cell_t             dn_data
);

  logic                   valid_r;
  tilt_cell_t             data_r;
  tilt_cell_t             data_nxt;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  dz;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    // arithmetic shift rounds toward minus infinity
    dx = up_data.y >>> stage_idx;
    dy = up_data.x >>> stage_idx;
    dz = $signed(atan_q24(stage_idx));
    data_nxt      = up_data;
    if (up_data.y > 0) begin
      data_nxt.x = up_data.x + dx;
      data_nxt.y = up_data.y - dy;
      data_nxt.z = up_data.z + dz;
    end else begin
      data_nxt.x = up_data.x - dx;
      data_nxt.y = up_data.y + dy;
      data_nxt.z = up_data.z - dz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[rtl/core/tilt_post.sv]
// ----------------------------------------------------------------------------
// tilt_post
// Output stage: clamp theta, apply special cases and quadrant mapping.
// ----------------------------------------------------------------------------
module tilt_post import tilt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  tilt_cell_t         up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic [ANGLE_W-1:0] dn_angle
);

  logic               valid_r;
  logic [ANGLE_W-1:0] angle_r;
  logic [ANGLE_W-1:0] angle_nxt;
  logic [Z_W-1:0]     z_clamp;
  logic [Z_W-1:0]     theta;
  logic [Z_W-1:0]     theta_up;
  logic [ANGLE_W-1:0] whole;
  logic [ANGLE_W-1:0] ceil_t;
  logic               x_ge;
  logic               y_ge;
  logic               x_le;
  logic               y_le;
  logic [ANGLE_W-1:0] res;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    if (up_data.z < 0) begin
      z_clamp = '0;
    end else if (up_data.z > $signed(DEG90_Q)) begin
      z_clamp = DEG90_Q;
    end else begin
      z_clamp = Z_W'(up_data.z);
    end

    case (up_data.meta.kind)
      KIND_FLAT:   theta = '0;
      KIND_VERT:   theta = DEG90_Q1;
      KIND_DIAG:   theta = DEG45_Q1;
      KIND_CORDIC: theta = z_clamp;
      default:     theta = '0;
    endcase

    theta_up = theta + FRAC_MASK;
    whole    = ANGLE_W'(theta[FRAC_BITS +: WHOLE_W]);
    ceil_t   = ANGLE_W'(theta_up[FRAC_BITS +: WHOLE_W]);

    x_ge = !up_data.meta.x_neg;
    y_ge = !up_data.meta.y_neg;
    x_le = up_data.meta.x_neg || up_data.meta.x_zero;
    y_le = up_data.meta.y_neg || up_data.meta.y_zero;

    // quadrant tests in priority order; both-zero lands in the first arm as 180
    if (x_ge && y_ge) begin
      res = ANG_HALF + whole;
    end else if (x_ge && y_le) begin
      res = ANG_HALF - ceil_t;
    end else if (x_le && y_le) begin
      res = whole;
    end else begin
      res = ANG_FULL - ceil_t;
    end
    angle_nxt = (res == ANG_FULL) ? '0 : res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      angle_r <= angle_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_angle = angle_r;

endmodule

[rtl/core/tilt_angle_from_xy.sv]
// Each transaction passes the input stage, every CORDIC cell and the result register in turn.
// Throughput: one transaction per cycle; every stage has its own valid bit, so
// bubbles collapse and a stalled result blocks input only once all stages are full.
// The rate is set by the row of CORDIC cells, one micro-rotation per cell.
// Reset (rst_n low, synchronous) empties the pipeline; payload is not cleared.
// ----------------------------------------------------------------------------
// tilt_angle_from_xy
// Whole-degree orientation angle 0..359 from a signed accelerometer x,y pair.
// ----------------------------------------------------------------------------
module tilt_angle_from_xy import tilt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tilt_in_if.sink     in_xy,
  tilt_out_if.source  out_ang
);

  // Pipeline links: link 0 leaves the input stage, link k+1 leaves cell k,
  // link CORDIC_STEPS feeds the output stage.
  logic       link_valid [0:CORDIC_STEPS];
  logic       link_ready [0:CORDIC_STEPS];
  tilt_cell_t link_data  [0:CORDIC_STEPS];

  // Input stage: |x|, |y| scaled by 2^24, sign flags, special-case class.
  tilt_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_xy.valid),
    .up_ready (in_xy.ready),
    .up_x     (in_xy.accel_x),
    .up_y     (in_xy.accel_y),
    .dn_valid (link_valid[0]),
    .dn_ready (link_ready[0]),
    .dn_data  (link_data[0])
  );

  // Row of vectoring cells; cell k shifts by k and uses atan(2^-k).
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    tilt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (TABLE_IDX_W'(k)),
      .up_valid  (link_valid[k]),
      .up_ready  (link_ready[k]),
      .up_data   (link_data[k]),
      .dn_valid  (link_valid[k+1]),
      .dn_ready  (link_ready[k+1]),
      .dn_data   (link_data[k+1])
    );
  end

  // Output stage: clamp, special cases, quadrant map, modulo 360, result register.
  tilt_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (link_valid[CORDIC_STEPS]),
    .up_ready (link_ready[CORDIC_STEPS]),
    .up_data  (link_data[CORDIC_STEPS]),
    .dn_valid (out_ang.valid),
    .dn_ready (out_ang.ready),
    .dn_angle (out_ang.angle_deg)
  );

  // A valid result is always a legal angle.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ang.valid |-> (out_ang.angle_deg < ANG_FULL))
    else $error("angle out of range");

  // Input backpressure only ever comes from a full pipeline behind a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xy.ready |-> (out_ang.valid && !out_ang.ready))
    else $error("input stalled without output backpressure");

  // The cycle after reset the output holds no transaction.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ang.valid)
    else $error("result valid right after reset");

  // The input stage fills only from an accepted input transaction.
  a_cell_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(link_valid[0]) |-> $past(in_xy.valid && in_xy.ready))
    else $error("input stage filled without an input transaction");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds x,y sample pairs into the tilt angle core and checks each returned
// angle vs. a typed answer or bench CORDIC model. Handshakes idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import tilt_pkg::*;

  // Generous bound on the length of the run.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_PAIRS = 1600;
  localparam int CALM_TAIL    = 200;   // final stretch runs with no idling
  localparam int SETTLE       = CORDIC_STEPS + 10;

  // One directed transaction. When typed is set, angle is the known answer;
  // otherwise the predictor supplies it.
  typedef struct {
    int x;
    int y;
    bit typed;
    int angle;
  } corner_row_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic [ANGLE_W-1:0]         angle;
  } pending_angle_t;

  logic clk = 1'b0;
  logic rst_n;

  tilt_in_if  in_xy ();
  tilt_out_if out_ang ();

  tilt_angle_from_xy uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_xy  (in_xy),
    .out_ang(out_ang)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // atan(2^-i) in degrees with pi = 3.14159265, scaled by 2^24.
  longint atan_step_deg [32] = '{
    754974721, 445687602, 235489089, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0
  };

  // Axes, both zero, equal magnitudes in all four quadrants, and the
  // extremes of both samples. Rows without a typed answer are predicted.
  corner_row_t corner_rows [25] = '{
    '{0, 0, 1, 180},
    '{5, 0, 1, 180},
    '{-5, 0, 1, 0},
    '{4095, 0, 1, 180},
    '{-4096, 0, 1, 0},
    '{0, 7, 1, 270},
    '{0, -7, 1, 89},
    '{0, 4095, 1, 270},
    '{0, -4096, 1, 89},
    '{100, 100, 1, 225},
    '{100, -100, 1, 134},
    '{-100, -100, 1, 45},
    '{-100, 100, 1, 314},
    '{4095, 4095, 1, 225},
    '{-4096, -4096, 1, 45},
    '{1, 1, 1, 225},
    '{-1, 1, 1, 314},
    '{4095, -4096, 0, 0},
    '{-4096, 4095, 0, 0},
    '{4095, 1, 0, 0},
    '{1, -4096, 0, 0},
    '{-1, 4095, 0, 0},
    '{-4096, -1, 0, 0},
    '{3, 4, 0, 0},
    '{-2731, 1234, 0, 0}
  };

  pending_angle_t angle_queue [$];   // expected angles, oldest first
  int             error_count = 0;
  int             cycle_count = 0;

  // Shared between the sender and the input monitor: whether the transaction
  // on the bus carries a typed answer, and that answer.
  bit                 next_typed;
  logic [ANGLE_W-1:0] next_angle;

  bit sender_idling;
  bit sink_idling;
  int stall_left = 0;

  // Whole-degree angle for one sample pair: theta = |atan(y/x)| from a
  // 24-fraction-bit vectoring CORDIC, then mapped by quadrant.
  function automatic logic [ANGLE_W-1:0] predict_angle(
      input logic signed [SAMPLE_W-1:0] x,
      input logic signed [SAMPLE_W-1:0] y);
    longint sx, sy, ax, ay, one_deg, theta, whole, ceil_theta, res;
    longint xv, yv, dx, dy;
    sx = x;
    sy = y;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    one_deg = longint'(1) << FRAC_BITS;
    if (ax == 0 && ay == 0)
      return ANGLE_W'(180);
    if (ay == 0) begin
      theta = 0;
    end else if (ax == 0) begin
      theta = 90 * one_deg + 1;
    end else if (ax == ay) begin
      theta = 45 * one_deg + 1;
    end else begin
      xv = ax * one_deg;
      yv = ay * one_deg;
      theta = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
        // >>> on a signed value rounds toward minus infinity
        dx = yv >>> i;
        dy = xv >>> i;
        if (yv > 0) begin
          xv = xv + dx;
          yv = yv - dy;
          theta = theta + atan_step_deg[i];
        end else begin
          xv = xv - dx;
          yv = yv + dy;
          theta = theta - atan_step_deg[i];
        end
      end
      if (theta < 0)
        theta = 0;
      if (theta > 90 * one_deg)
        theta = 90 * one_deg;
    end
    whole      = theta >>> FRAC_BITS;
    ceil_theta = (theta + one_deg - 1) >>> FRAC_BITS;
    // Quadrant tests in this exact order; the axes fall to the first match.
    if (sx >= 0 && sy >= 0)
      res = 180 + whole;
    else if (sx >= 0 && sy <= 0)
      res = 180 - ceil_theta;
    else if (sx <= 0 && sy <= 0)
      res = whole;
    else
      res = 360 - ceil_theta;
    res = res % 360;
    if (res < 0)
      res = res + 360;
    return ANGLE_W'(res);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0d] %s", cycle_count, what);
    error_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pair(input logic signed [SAMPLE_W-1:0] x,
                           input logic signed [SAMPLE_W-1:0] y,
                           input bit typed, input logic [ANGLE_W-1:0] angle);
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      in_xy.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_xy.valid   = 1'b1;
    in_xy.accel_x = x;
    in_xy.accel_y = y;
    next_typed    = typed;
    next_angle    = angle;
    do @(posedge clk); while (!in_xy.ready);
    @(negedge clk);
  endtask

  // Random pair, weighted toward the places where the CORDIC is delicate:
  // near the axes, on and near the diagonals, and tiny magnitudes.
  task automatic pick_pair(output logic signed [SAMPLE_W-1:0] x,
                           output logic signed [SAMPLE_W-1:0] y);
    int mode, m, n;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2, 3: begin
        x = SAMPLE_W'($urandom);
        y = SAMPLE_W'($urandom);
      end
      4: begin
        x = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
        y = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
      end
      5: begin
        if ($urandom_range(0, 1)) begin
          x = SAMPLE_W'($urandom);
          y = SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
        end else begin
          x = SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
          y = SAMPLE_W'($urandom);
        end
      end
      6: begin
        m = $urandom_range(1, 4095);
        x = $urandom_range(0, 1) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
        y = $urandom_range(0, 1) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
      end
      default: begin
        m = $urandom_range(1, 4095);
        n = m + int'($urandom_range(0, 6)) - 3;
        if (n < 0)
          n = 0;
        if (n > 4095)
          n = 4095;
        x = $urandom_range(0, 1) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
        y = $urandom_range(0, 1) ? SAMPLE_W'(-n) : SAMPLE_W'(n);
      end
    endcase
  endtask

  // Result side: ready drops in short bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ang.ready = 1'b0;
      stall_left--;
    end else if (sink_idling && $urandom_range(0, 5) == 0) begin
      out_ang.ready = 1'b0;
      stall_left = $urandom_range(1, 3) - 1;
    end else begin
      out_ang.ready = 1'b1;
    end
  end

  // Both handshakes are sampled here, at the rising edge.
  always @(posedge clk) begin
    pending_angle_t item;
    pending_angle_t want;
    if (rst_n && in_xy.valid && in_xy.ready) begin
      item.x     = in_xy.accel_x;
      item.y     = in_xy.accel_y;
      item.angle = next_typed ? next_angle : predict_angle(in_xy.accel_x, in_xy.accel_y);
      angle_queue.push_back(item);
    end
    if (rst_n && out_ang.valid && out_ang.ready) begin
      if (angle_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected angle %0d with no transaction pending",
                                  out_ang.angle_deg));
      end else begin
        want = angle_queue.pop_front();
        if (out_ang.angle_deg !== want.angle)
          report_mismatch($sformatf("x=%0d y=%0d: angle %0d, expected %0d",
                                    want.x, want.y, out_ang.angle_deg, want.angle));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tilt_angle_from_xy: mismatch");
      $finish;
    end
  end

  initial begin
    logic signed [SAMPLE_W-1:0] rx, ry;
    rst_n           = 1'b0;
    in_xy.valid     = 1'b0;
    in_xy.accel_x   = '0;
    in_xy.accel_y   = '0;
    out_ang.ready   = 1'b0;
    next_typed      = 1'b0;
    next_angle      = '0;
    sender_idling   = 1'b1;
    sink_idling     = 1'b1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners first.
    foreach (corner_rows[i])
      send_pair(SAMPLE_W'(corner_rows[i].x), SAMPLE_W'(corner_rows[i].y),
                corner_rows[i].typed, ANGLE_W'(corner_rows[i].angle));

    // Random pairs. Each side gets its own quiet stretch in the middle, and
    // the tail runs flat out. Halfway through, the sender holds off until
    // the pipeline has drained completely.
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      sender_idling = (n < RANDOM_PAIRS - CALM_TAIL) && !(n >= 400 && n < 600);
      sink_idling   = (n < RANDOM_PAIRS - CALM_TAIL) && !(n >= 900 && n < 1100);
      if (n == RANDOM_PAIRS / 2) begin
        in_xy.valid = 1'b0;
        while (angle_queue.size() != 0) @(negedge clk);
      end
      pick_pair(rx, ry);
      send_pair(rx, ry, 1'b0, '0);
    end
    in_xy.valid = 1'b0;

    // Drain, then linger a full pipeline depth to catch stray results.
    while (angle_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (error_count == 0) begin
      $display("tilt_angle_from_xy: match");
    end else begin
      $display("tilt_angle_from_xy: mismatch");
    end
    $finish;
  end

endmodule
